[hdl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// Packed bit-field array package
// Shared widths, codes and the decoded access record.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int WORD_BITS = 64;
    localparam int IDX_W     = 16;
    localparam int BPE_W     = 7;
    localparam int CNT_W     = 17;
    localparam int POS_W     = IDX_W + 6;
    localparam int SUM_W     = POS_W + 1;
    localparam int SH_W      = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = CNT_W;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_WIDE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BPE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [1:0]           status;
        logic [IDX_W-1:0]     wi;
        logic [SH_W-1:0]      sh;
        logic                 straddle;
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] val;
    } t_dec;

endpackage

[hdl/pba_if.sv]
// ----------------------------------------------------------------------------
// Packed bit-field array channels
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pba_in_if;
    import pba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [IDX_W-1:0]     index;
    logic [WORD_BITS-1:0] value;
    modport source (output valid, op, index, value, input ready);
    modport sink   (input valid, op, index, value, output ready);
endinterface

interface pba_out_if;
    import pba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] read_value;
    logic [1:0]           status;
    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface pba_cfg_if;
    import pba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/pba_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pba_decode.sv]
// ----------------------------------------------------------------------------
// Packed bit-field array access decode
// Bit position, word index, shift, mask and error checks for one request.
// ----------------------------------------------------------------------------
module pba_decode import pba_pkg::*; #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                 i_op,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [BPE_W-1:0]     i_bpe,
    input  logic [CNT_W-1:0]     i_count,
    output t_dec                 o_dec
);

    localparam logic [SUM_W-1:0] TOTAL_BITS = SUM_W'(MEM_WORDS * WORD_BITS);

    logic [BPE_W-1:0]     w;
    logic [POS_W-1:0]     pos;
    logic [SUM_W-1:0]     pos_end;
    logic [5:0]           off;
    logic [WORD_BITS-1:0] mask;
    logic                 range_err;
    logic                 wide_err;

    always_comb begin
        if (i_bpe == '0) begin
            w = BPE_W'(1);
        end else if (i_bpe > BPE_W'(WORD_BITS)) begin
            w = BPE_W'(WORD_BITS);
        end else begin
            w = i_bpe;
        end
        pos       = POS_W'(i_index) * POS_W'(w);
        pos_end   = SUM_W'(pos) + SUM_W'(w);
        off       = pos[5:0];
        mask      = (w == BPE_W'(WORD_BITS)) ? '1 :
                    ((WORD_BITS'(1) << w[5:0]) - WORD_BITS'(1));
        range_err = (CNT_W'(i_index) >= i_count) || (pos_end > TOTAL_BITS);
        wide_err  = (i_op == OP_WRITE) && ((i_value & ~mask) != '0);

        o_dec.op       = i_op;
        o_dec.status   = range_err ? ST_RANGE : (wide_err ? ST_WIDE : ST_OK);
        o_dec.wi       = pos[POS_W-1:6];
        o_dec.sh       = SH_W'(8'd128 - 8'(off) - 8'(w));
        o_dec.straddle = (8'(off) + 8'(w)) > 8'(WORD_BITS);
        o_dec.mask     = mask;
        o_dec.val      = i_value;
    end

endmodule

[hdl/pba_merge.sv]
// ----------------------------------------------------------------------------
// Packed bit-field array field merge
// Extract an entry from two adjacent words, or insert a new entry into them.
// ----------------------------------------------------------------------------
module pba_merge import pba_pkg::*; (
    input  t_dec                 i_dec,
    input  logic [WORD_BITS-1:0] i_even_data,
    input  logic [WORD_BITS-1:0] i_odd_data,
    output logic [WORD_BITS-1:0] o_read_value,
    output logic [WORD_BITS-1:0] o_hi_word,
    output logic [WORD_BITS-1:0] o_lo_word
);

    logic [2*WORD_BITS-1:0] cat;
    logic [2*WORD_BITS-1:0] sel;
    logic [2*WORD_BITS-1:0] m2;
    logic [2*WORD_BITS-1:0] v2;
    logic [2*WORD_BITS-1:0] upd;

    always_comb begin
        cat = i_dec.wi[0] ? {i_odd_data, i_even_data} : {i_even_data, i_odd_data};
        sel = cat >> i_dec.sh;
        m2  = {{WORD_BITS{1'b0}}, i_dec.mask} << i_dec.sh;
        v2  = {{WORD_BITS{1'b0}}, i_dec.val} << i_dec.sh;
        upd = (cat & ~m2) | v2;

        o_read_value = (i_dec.op == OP_READ && i_dec.status == ST_OK) ?
                       (sel[WORD_BITS-1:0] & i_dec.mask) : '0;
        o_hi_word    = upd[2*WORD_BITS-1:WORD_BITS];
        o_lo_word    = upd[WORD_BITS-1:0];
    end

endmodule

[hdl/packed_bitfield_array.sv]
// ----------------------------------------------------------------------------
// Packed bit-field array
// Array of 1..64-bit unsigned entries packed MSB-first into 64-bit words,
// stored in even/odd word banks so a straddling entry reaches both words.
// ----------------------------------------------------------------------------
//  port    dir   fields                 role
//  i_in    sink  op, index, value       read or write request
//  o_out   src   read_value, status     one response per request
//  i_cfg   sink  index, data            register write, always ready
//
//  A request passes the decode stage, the bank read and the merge in turn;
//  one request per cycle is sustained while the response side is ready.
//  Read-modify-write data is forwarded to the next access of the same word.
//  Reset clears the banks one address at a time; i_in.ready is low meanwhile.
//  A stalled response holds the pipeline; requests still fill free stages.
// ----------------------------------------------------------------------------
module packed_bitfield_array import pba_pkg::*; #(
    parameter int MEM_WORDS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pba_in_if.sink        i_in,
    pba_out_if.source     o_out,
    pba_cfg_if.sink       i_cfg
);

    localparam int BANK_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int AW         = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;

    logic [BPE_W-1:0]     r_bpe;
    logic [CNT_W-1:0]     r_count;

    logic                 r_clearing;
    logic [AW-1:0]        r_clr_addr;

    logic                 r_s1_valid;
    logic                 r_s1_op;
    logic [IDX_W-1:0]     r_s1_index;
    logic [WORD_BITS-1:0] r_s1_value;

    logic                 r_s2_valid;
    t_dec                 r_s2_dec;
    logic [AW-1:0]        r_s2_eaddr;
    logic [AW-1:0]        r_s2_oaddr;

    logic                 r_fe_valid;
    logic [AW-1:0]        r_fe_addr;
    logic [WORD_BITS-1:0] r_fe_data;
    logic                 r_fo_valid;
    logic [AW-1:0]        r_fo_addr;
    logic [WORD_BITS-1:0] r_fo_data;

    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_rv;
    logic [1:0]           r_out_status;

    t_dec                 s1_dec;
    logic [IDX_W:0]       s1_wi1;
    logic [AW-1:0]        s1_eaddr;
    logic [AW-1:0]        s1_oaddr;

    logic                 out_free;
    logic                 s2_adv;
    logic                 s1_to_s2;
    logic                 s1_free;

    logic [WORD_BITS-1:0] e_rdata;
    logic [WORD_BITS-1:0] o_rdata;
    logic [WORD_BITS-1:0] e_data;
    logic [WORD_BITS-1:0] o_data;
    logic [WORD_BITS-1:0] rv;
    logic [WORD_BITS-1:0] hi_word;
    logic [WORD_BITS-1:0] lo_word;

    logic                 wr;
    logic                 e_wr;
    logic                 o_wr;
    logic [WORD_BITS-1:0] e_wdata;
    logic [WORD_BITS-1:0] o_wdata;

    logic                 e_we;
    logic [AW-1:0]        e_waddr;
    logic [WORD_BITS-1:0] e_wd;
    logic                 o_we;
    logic [AW-1:0]        o_waddr;
    logic [WORD_BITS-1:0] o_wd;

    assign out_free = !r_out_valid || o_out.ready;
    assign s2_adv   = r_s2_valid && out_free;
    assign s1_to_s2 = r_s1_valid && (!r_s2_valid || s2_adv);
    assign s1_free  = !r_s1_valid || s1_to_s2;

    assign i_in.ready  = s1_free && !r_clearing;
    assign i_cfg.ready = 1'b1;

    pba_decode #(
        .MEM_WORDS (MEM_WORDS)
    ) u_decode (
        .i_op    (r_s1_op),
        .i_index (r_s1_index),
        .i_value (r_s1_value),
        .i_bpe   (r_bpe),
        .i_count (r_count),
        .o_dec   (s1_dec)
    );

    assign s1_wi1   = (IDX_W + 1)'(s1_dec.wi) + (IDX_W + 1)'(1);
    assign s1_eaddr = s1_wi1[AW:1];
    assign s1_oaddr = s1_dec.wi[AW:1];

    assign e_data = (r_fe_valid && r_fe_addr == r_s2_eaddr) ? r_fe_data : e_rdata;
    assign o_data = (r_fo_valid && r_fo_addr == r_s2_oaddr) ? r_fo_data : o_rdata;

    pba_merge u_merge (
        .i_dec        (r_s2_dec),
        .i_even_data  (e_data),
        .i_odd_data   (o_data),
        .o_read_value (rv),
        .o_hi_word    (hi_word),
        .o_lo_word    (lo_word)
    );

    assign wr      = s2_adv && r_s2_dec.op == OP_WRITE && r_s2_dec.status == ST_OK;
    assign e_wr    = wr && (!r_s2_dec.wi[0] || r_s2_dec.straddle);
    assign o_wr    = wr && (r_s2_dec.wi[0] || r_s2_dec.straddle);
    assign e_wdata = r_s2_dec.wi[0] ? lo_word : hi_word;
    assign o_wdata = r_s2_dec.wi[0] ? hi_word : lo_word;

    assign e_we    = r_clearing || e_wr;
    assign e_waddr = r_clearing ? r_clr_addr : r_s2_eaddr;
    assign e_wd    = r_clearing ? '0 : e_wdata;
    assign o_we    = r_clearing || o_wr;
    assign o_waddr = r_clearing ? r_clr_addr : r_s2_oaddr;
    assign o_wd    = r_clearing ? '0 : o_wdata;

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wd),
        .i_re    (s1_to_s2),
        .i_raddr (s1_eaddr),
        .o_rdata (e_rdata)
    );

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (o_waddr),
        .i_wdata (o_wd),
        .i_re    (s1_to_s2),
        .i_raddr (s1_oaddr),
        .o_rdata (o_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpe       <= BPE_W'(1);
            r_count     <= CNT_W'(65536);
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fe_valid  <= 1'b0;
            r_fo_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_BPE:   r_bpe   <= i_cfg.data[BPE_W-1:0];
                    CFG_COUNT: r_count <= i_cfg.data;
                    default:   r_bpe   <= r_bpe;
                endcase
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(BANK_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end

            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_to_s2) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_to_s2) begin
                r_s2_valid <= 1'b1;
                r_fe_valid <= e_wr;
                r_fo_valid <= o_wr;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_op    <= i_in.op;
            r_s1_index <= i_in.index;
            r_s1_value <= i_in.value;
        end
        if (s1_to_s2) begin
            r_s2_dec   <= s1_dec;
            r_s2_eaddr <= s1_eaddr;
            r_s2_oaddr <= s1_oaddr;
            r_fe_addr  <= r_s2_eaddr;
            r_fe_data  <= e_wdata;
            r_fo_addr  <= r_s2_oaddr;
            r_fo_data  <= o_wdata;
        end
        if (s2_adv) begin
            r_out_rv     <= rv;
            r_out_status <= r_s2_dec.status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_rv;
    assign o_out.status     = r_out_status;

endmodule

[verif/packed_bitfield_array_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed bit-field array testbench
// A table of directed reads, writes and register settings, then random
// phases, each with its own entry width and entry count. Every accepted word
// runs through a local shadow of the packed store, and each response word is
// compared in order. Both ends idle at random; the response side once holds
// off long; the request side drains before register writes and once mid-phase.
// ----------------------------------------------------------------------------
module packed_bitfield_array_tb;
    import pba_pkg::*;

    localparam int MEM_WORDS        = 1024;
    localparam int ARRAY_BITS       = MEM_WORDS * WORD_BITS;
    localparam int PHASES           = 14;
    localparam int PHASE_WORDS      = 100;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int N_DIRECTED       = 30;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    typedef enum logic {ROW_REG, ROW_ACC} t_row_kind;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_value;
        logic [1:0]           status;
    } t_entry_result;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] sel;
        logic [CFG_DAT_W-1:0] data;
        logic                 op;
        logic [IDX_W-1:0]     index;
        logic [WORD_BITS-1:0] value;
        logic                 by_hand;
        logic [WORD_BITS-1:0] exp_read;
        logic [1:0]           exp_status;
    } t_dir_row;

    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd0,     64'd0,     1'b1, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd65535, ONES,      1'b1, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd65535, 64'd1,     1'b1, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd65535, 64'd0,     1'b1, 64'd1, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd7,     64'd2,     1'b1, 64'd0, ST_WIDE},
        '{ROW_REG, CFG_BPE,   17'd64,    OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd1023,  ONES,      1'b1, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd1023,  64'd0,     1'b1, ONES,  ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd1024,  64'd0,     1'b1, 64'd0, ST_RANGE},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd0,     64'h8000_0000_0000_0001,
          1'b0, 64'd0, ST_OK},
        '{ROW_REG, CFG_BPE,   17'd0,     OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd5,     64'd3,     1'b1, 64'd0, ST_WIDE},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd0,     ONES,      1'b0, 64'd0, ST_OK},
        '{ROW_REG, CFG_BPE,   17'h1FFFF, OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd1023,  64'd0,     1'b1, ONES,  ST_OK},
        '{ROW_REG, CFG_COUNT, 17'd0,     OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd0,     64'd0,     1'b1, 64'd0, ST_RANGE},
        '{ROW_REG, CFG_BPE,   17'd13,    OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_REG, CFG_COUNT, 17'h1FFFF, OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd4,     64'h1FFF,  1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd4,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd65535, ONES,      1'b1, 64'd0, ST_RANGE},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd5041,  64'd0,     1'b1, 64'd0, ST_RANGE},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd5040,  64'h1ABC,  1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd5040,  64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd3,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_REG, CFG_COUNT, 17'd1,     OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_READ,  16'd1,     64'd0,     1'b1, 64'd0, ST_RANGE},
        '{ROW_REG, CFG_BPE,   17'd1,     OP_READ,  16'd0,     64'd0,     1'b0, 64'd0, ST_OK},
        '{ROW_ACC, CFG_BPE,   17'd0,     OP_WRITE, 16'd0,     64'd1,     1'b0, 64'd0, ST_OK}
    };

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   fail_count;

    logic [WORD_BITS-1:0] shadow_words [MEM_WORDS];
    logic [BPE_W-1:0]     shadow_bpe;
    logic [CNT_W-1:0]     shadow_count;
    t_entry_result        expected_results [$];

    pba_in_if  req_if ();
    pba_out_if rsp_if ();
    pba_cfg_if reg_if ();

    packed_bitfield_array #(
        .MEM_WORDS (MEM_WORDS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .i_cfg   (reg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned entry_width();
        if (shadow_bpe == 0) return 1;
        if (shadow_bpe > WORD_BITS) return WORD_BITS;
        return int'(shadow_bpe);
    endfunction

    function automatic logic [WORD_BITS-1:0] width_mask(int unsigned w);
        return (w >= WORD_BITS) ? ONES : (64'd1 << w) - 64'd1;
    endfunction

    // Work on a two-word window so a straddling entry needs no special path.
    function automatic t_entry_result access_entry(logic op, logic [IDX_W-1:0] idx,
                                                   logic [WORD_BITS-1:0] val);
        int unsigned            w;
        int unsigned            pos;
        int unsigned            wi;
        int unsigned            lsb;
        logic [WORD_BITS-1:0]   mask;
        logic [2*WORD_BITS-1:0] pair;
        logic [2*WORD_BITS-1:0] field;
        logic [2*WORD_BITS-1:0] moved;
        t_entry_result          res;
        w    = entry_width();
        mask = width_mask(w);
        pos  = idx * w;
        res  = '0;
        if (idx >= shadow_count || pos + w > ARRAY_BITS) begin
            res.status = ST_RANGE;
            return res;
        end
        wi  = pos / WORD_BITS;
        lsb = 2 * WORD_BITS - (pos % WORD_BITS) - w;
        pair[2*WORD_BITS-1:WORD_BITS] = shadow_words[wi];
        pair[WORD_BITS-1:0] = (wi + 1 < MEM_WORDS) ? shadow_words[wi+1] : ONES & 64'd0;
        field = {{WORD_BITS{1'b0}}, mask} << lsb;
        if (op == OP_READ) begin
            moved = pair >> lsb;
            res.read_value = moved[WORD_BITS-1:0] & mask;
        end else if ((val & ~mask) != 0) begin
            res.status = ST_WIDE;
        end else begin
            pair = (pair & ~field) | ({{WORD_BITS{1'b0}}, val} << lsb);
            shadow_words[wi] = pair[2*WORD_BITS-1:WORD_BITS];
            if (wi + 1 < MEM_WORDS) shadow_words[wi+1] = pair[WORD_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [WORD_BITS-1:0] want,
                                   logic [WORD_BITS-1:0] got);
        fail_count++;
        $error("%s: expected %h, actual %h", field, want, got);
    endtask

    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] data);
        hold_until_drained();
        reg_if.valid <= 1'b1;
        reg_if.index <= sel;
        reg_if.data  <= data;
        do @(posedge i_clk); while (!reg_if.ready);
        if (sel == CFG_BPE) shadow_bpe = data[BPE_W-1:0];
        else shadow_count = data;
        @(negedge i_clk);
        reg_if.valid <= 1'b0;
    endtask

    task automatic offer_access(logic op, logic [IDX_W-1:0] idx, logic [WORD_BITS-1:0] val,
                                logic by_hand, t_entry_result hand_res);
        int unsigned   gap;
        t_entry_result res;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.index <= idx;
        req_if.value <= val;
        do @(posedge i_clk); while (!req_if.ready);
        res = access_entry(op, idx, val);
        expected_results.push_back(by_hand ? hand_res : res);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 5);
            if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
            if (hold != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_entry_result want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 64'd0, rsp_if.read_value);
            end else begin
                want = expected_results.pop_front();
                if (rsp_if.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, rsp_if.read_value);
                if (rsp_if.status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(rsp_if.status));
            end
        end
    end

    initial begin : stimulus
        int unsigned          w;
        int unsigned          cap;
        int unsigned          lim;
        int unsigned          base;
        int unsigned          pick;
        logic [CFG_DAT_W-1:0] data;
        logic [BPE_W-1:0]     bpe;
        logic                 op;
        logic [IDX_W-1:0]     idx;
        logic [WORD_BITS-1:0] val;
        t_dir_row             row;
        fail_count   = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = OP_READ;
        req_if.index = '0;
        req_if.value = '0;
        reg_if.valid = 1'b0;
        reg_if.index = CFG_BPE;
        reg_if.data  = '0;
        foreach (shadow_words[i]) shadow_words[i] = '0;
        shadow_bpe   = 7'd1;
        shadow_count = 17'h10000;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_REG)
                write_register(row.sel, row.data);
            else
                offer_access(row.op, row.index, row.value, row.by_hand,
                             t_entry_result'{row.exp_read, row.exp_status});
        end

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: bpe = 7'd0;
                1: bpe = BPE_W'($urandom_range(65, 127));
                2: bpe = 7'd64;
                3: bpe = 7'd1;
                default: bpe = BPE_W'($urandom_range(1, 64));
            endcase
            data = CFG_DAT_W'($urandom);
            data[BPE_W-1:0] = bpe;
            write_register(CFG_BPE, data);
            w   = entry_width();
            cap = ARRAY_BITS / w;
            case ($urandom_range(0, 19))
                0:       data = '0;
                1, 2:    data = 17'h10000;
                3, 4:    data = '1;
                default: data = CFG_DAT_W'($urandom_range(1,
                                    (cap > 65528) ? 65536 : cap + 8));
            endcase
            write_register(CFG_COUNT, data);
            lim = ((shadow_count < cap) ? shadow_count : cap) + 2;
            if (lim > 65535) lim = 65535;
            base = $urandom_range(0, lim);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 5 && n == PHASE_WORDS / 2) hold_until_drained();
                pick = $urandom_range(0, 9);
                if (pick < 4) idx = IDX_W'(base + $urandom_range(0, 31));
                else if (pick < 8) idx = IDX_W'($urandom_range(0, lim));
                else idx = IDX_W'($urandom);
                op  = 1'($urandom_range(0, 1));
                val = {$urandom, $urandom};
                if ($urandom_range(0, 4) != 0) val &= width_mask(w);
                offer_access(op, idx, val, 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
hdl/pba_pkg.sv
hdl/pba_if.sv
hdl/pba_ram.sv
hdl/pba_decode.sv
hdl/pba_merge.sv
hdl/packed_bitfield_array.sv
verif/packed_bitfield_array_tb.sv
